// ===== sv/shp3_pkg.sv =====
// ----------------------------------------------------------------------------
// shp3_pkg
// Shared types, constants and the per-pixel sharpen kernel for the 3x3
// sharpen filter.
// ----------------------------------------------------------------------------
package shp3_pkg;

	localparam int PIX_W      = 32;
	localparam int LANE_W     = 8;
	localparam int LANES      = 3;
	localparam int TAPS       = 9;
	localparam int CENTER_TAP = 4;
	localparam int IMG_W_W    = 13;
	localparam int ROW_W      = 16;
	localparam int COL_OUT_W  = 12;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 64;
	localparam int SUM_W      = 12;

	localparam logic [IMG_W_W-1:0] IMG_W_RESET = 13'd640;
	localparam logic [ROW_W-1:0]   IMG_H_RESET = 16'd480;
	localparam logic [ROW_W-1:0]   MIN_DIM     = 16'd3;
	localparam logic [SUM_W-1:0]   LANE_MAX    = 12'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 8'd0,
		REG_IMAGE_HEIGHT = 8'd1
	} cfg_reg_t;

	typedef logic [TAPS-1:0][PIX_W-1:0] win_t;

	// Nine times the center minus the eight neighbors, per color byte,
	// clamped to 0..255. Alpha comes from the center pixel.
	function automatic logic [PIX_W-1:0] sharpen_pix(input win_t w);
		logic [PIX_W-1:0]  res;
		logic [SUM_W-1:0]  sum;
		logic [SUM_W-1:0]  ten;
		logic [SUM_W-1:0]  diff;
		logic [LANE_W-1:0] ctr;
		res = '0;
		res[PIX_W-1 -: LANE_W] = w[CENTER_TAP][PIX_W-1 -: LANE_W];
		for (int l = 0; l < LANES; l++) begin
			sum = '0;
			for (int t = 0; t < TAPS; t++) begin
				sum = sum + SUM_W'(w[t][LANE_W*l +: LANE_W]);
			end
			ctr  = w[CENTER_TAP][LANE_W*l +: LANE_W];
			ten  = {1'b0, ctr, 3'b000} + {3'b000, ctr, 1'b0};
			diff = ten - sum;
			if (ten < sum) begin
				res[LANE_W*l +: LANE_W] = '0;
			end else if (diff > LANE_MAX) begin
				res[LANE_W*l +: LANE_W] = '1;
			end else begin
				res[LANE_W*l +: LANE_W] = diff[LANE_W-1:0];
			end
		end
		return res;
	endfunction

endpackage

// ===== sv/shp3_ram.sv =====
// ----------------------------------------------------------------------------
// shp3_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module shp3_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/sharpen_3x3_rgba_filter_top.sv =====
// ----------------------------------------------------------------------------
// sharpen_3x3_rgba_filter_top
// 3x3 sharpen filter over a raster-order stream of packed RGBA pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and gives one sharpened pixel for each
// interior pixel of the frame; border pixels produce no output beat. A result
// leaves after the pixel that completes its window is accepted, passing the
// registered read of the line buffer, the window shift and the output
// register. Both rows of history live in a single line buffer RAM of
// MAX_WIDTH entries that is read and rewritten at the same column once per
// pixel, so the rate is one pixel per clock whenever the output side is
// ready. The line buffer needs no clearing after reset. Width and height may
// be written while no pixel is in flight, also inside a frame; a new value
// applies from the next pixel on.
module sharpen_3x3_rgba_filter_top
	import shp3_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // pixel_in[31:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_out[31:0], out_col[43:32], out_row[59:44]
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (EW > IMG_W_W) ? EW : IMG_W_W;

	logic [IMG_W_W-1:0] img_w_q;
	logic [ROW_W-1:0]   img_h_q;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;

	logic [XW-1:0]      img_w_ext;
	logic [XW-1:0]      eff_w;
	logic [ROW_W-1:0]   eff_h;
	logic               row_end;
	logic               frame_end;
	logic               emit;

	logic               valid_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [CW-1:0]      col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               emit_s1;
	logic               last_s1;

	logic               valid_s2;
	logic [CW-1:0]      col_s2;
	logic [ROW_W-1:0]   row_s2;
	logic               last_s2;

	win_t               win_q;

	logic               out_valid_q;
	logic [PIX_W-1:0]   pix_q;
	logic [COL_OUT_W-1:0] ocol_q;
	logic [ROW_W-1:0]   orow_q;
	logic               olast_q;

	logic               accept;
	logic               adv1;
	logic               adv2;
	logic [2*PIX_W-1:0] lb_rdata;
	logic [PIX_W-1:0]   top_px;
	logic [PIX_W-1:0]   mid_px;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= IMG_W_RESET;
			img_h_q <= IMG_H_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					img_w_q <= cfg_data[IMG_W_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					img_h_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		img_w_ext = XW'(img_w_q);
		if (img_w_ext < XW'(MIN_DIM)) begin
			eff_w = XW'(MIN_DIM);
		end else if (img_w_ext > XW'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end else begin
			eff_w = img_w_ext;
		end
		eff_h     = (img_h_q < MIN_DIM) ? MIN_DIM : img_h_q;
		row_end   = XW'(col_q) >= (eff_w - XW'(1));
		frame_end = row_end && (row_q >= (eff_h - ROW_W'(1)));
		emit      = (col_q >= CW'(2)) && (row_q >= ROW_W'(2));
	end

	assign adv2     = valid_s2 && (!out_valid_q || m_tready);
	assign adv1     = valid_s1 && (!valid_s2 || adv2);
	assign s_tready = !valid_s1 || adv1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= emit;
			last_s1 <= frame_end;
		end
	end

	shp3_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.wr_en  (adv1),
		.wr_addr(col_s1),
		.wr_data({mid_px, px_s1}),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(lb_rdata)
	);

	assign top_px = lb_rdata[2*PIX_W-1:PIX_W];
	assign mid_px = lb_rdata[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top_px;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_px;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= emit_s1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			col_s2  <= col_s1 - CW'(1);
			row_s2  <= row_s1 - ROW_W'(1);
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			pix_q   <= sharpen_pix(win_q);
			ocol_q  <= COL_OUT_W'(col_s2);
			orow_q  <= row_s2;
			olast_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{(OUT_DATA_W - PIX_W - COL_OUT_W - ROW_W){1'b0}}, orow_q, ocol_q, pix_q};

	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv2) |=> $stable(win_q))
		else $error("Window changed under a stalled result.");

	a_lb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |=> $stable(lb_rdata))
		else $error("Line buffer read data lost while stage one stalled.");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (col_s2 != '0 && row_s2 != '0))
		else $error("Border pixel reached the result stage.");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end) |=> (col_q == '0))
		else $error("Column counter did not wrap at row end.");

endmodule

// ===== tb/sv/sharpen_3x3_rgba_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_rgba_filter_top_tb
// Self-checking bench for the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order while a behavioral copy of the filter
// predicts every output beat, which is compared field by field as it leaves
// the block. Runs cover the reset frame size, clamped and out-of-range sizes,
// size changes inside a frame and random phases with idle and backpressure
// patterns on both stream ports.
module sharpen_3x3_rgba_filter_top_tb
	import shp3_pkg::*;
();

	localparam int MAX_W           = 4096;
	localparam int DEFAULT_W       = 640;
	localparam int DEFAULT_H       = 480;
	localparam int LEAD_PIXELS     = 60;
	localparam int CLOSE_PIXELS    = 4;
	localparam int RESET_CYCLES    = 9;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_CYCLES = 1_000_000;
	localparam int END_WAIT_CYCLES = 10_000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_PIXELS    = 60;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [PIX_W-1:0]     pix;
		logic [COL_OUT_W-1:0] col;
		logic [ROW_W-1:0]     row;
		logic                 last;
	} sharp_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] ring;
		logic [PIX_W-1:0] center;
		logic [PIX_W-1:0] want;
	} probe_frame_t;

	// Each row is one 3x3 frame: eight equal neighbors around one center pixel.
	localparam probe_frame_t PROBE_FRAMES [3] = '{
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'h00FF_FFFF, 32'hAB00_0000, 32'hAB00_0000},
		'{32'h0000_FF71, 32'h5AFF_0080, 32'h5AFF_00F8}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [IMG_W_W-1:0] size_w = IMG_W_W'(DEFAULT_W);
	logic [ROW_W-1:0]   size_h = ROW_W'(DEFAULT_H);
	int unsigned        at_col = 0;
	int unsigned        at_row = 0;
	bit [PIX_W-1:0]     hist_far  [MAX_W];
	bit [PIX_W-1:0]     hist_near [MAX_W];
	bit [PIX_W-1:0]     win       [TAPS];

	sharp_beat_t  pending_beats [$];
	sharp_beat_t  head_beat;
	int unsigned  tx_idle_pct  = 0;
	int unsigned  rx_stall_pct = 0;
	bit           rx_hold      = 1'b0;
	logic [7:0]   flat_level   = 8'd128;
	int           errors       = 0;
	int           pixels_sent  = 0;
	int           beats_seen   = 0;
	int           frame_ends   = 0;

	sharpen_3x3_rgba_filter_top #(
		.MAX_WIDTH(MAX_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [LANE_W-1:0] sharpen_lane(input int ctr, input int total);
		int d;
		d = 10 * ctr - total;
		if (d < 0) begin
			return '0;
		end
		if (d > 255) begin
			return '1;
		end
		return LANE_W'(d);
	endfunction

	task automatic predict_pixel(input logic [PIX_W-1:0] px, output bit hit,
			output sharp_beat_t beat);
		int unsigned    w;
		int unsigned    h;
		int unsigned    c;
		int unsigned    r;
		bit [PIX_W-1:0] top;
		bit [PIX_W-1:0] mid;
		bit             row_end;
		bit             frame_end;
		int             total;
		int             k;
		int             l;
		w = size_w;
		if (w < 3) begin
			w = 3;
		end
		if (w > MAX_W) begin
			w = MAX_W;
		end
		h = size_h;
		if (h < 3) begin
			h = 3;
		end
		c = at_col;
		r = at_row;
		row_end   = (c >= w - 1);
		frame_end = row_end && (r >= h - 1);
		top = '0;
		mid = '0;
		if (c < MAX_W) begin
			top = hist_far[c];
			mid = hist_near[c];
			hist_far[c]  = mid;
			hist_near[c] = px;
		end
		for (k = 0; k < 3; k++) begin
			win[3*k]   = win[3*k+1];
			win[3*k+1] = win[3*k+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		hit  = (c >= 2) && (r >= 2);
		beat = '0;
		if (hit) begin
			beat.pix[PIX_W-1 -: LANE_W] = win[CENTER_TAP][PIX_W-1 -: LANE_W];
			for (l = 0; l < LANES; l++) begin
				total = 0;
				for (k = 0; k < TAPS; k++) begin
					total += int'(win[k][LANE_W*l +: LANE_W]);
				end
				beat.pix[LANE_W*l +: LANE_W] =
					sharpen_lane(int'(win[CENTER_TAP][LANE_W*l +: LANE_W]), total);
			end
			beat.col  = COL_OUT_W'(c - 1);
			beat.row  = ROW_W'(r - 1);
			beat.last = frame_end;
		end
		if (row_end) begin
			at_col = 0;
			at_row = frame_end ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			at_col = c + 1;
		end
	endtask

	// Lanes are either fully random, near a common level, or saturated to all
	// zeros or all ones.
	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] p;
		int unsigned      kind;
		int               l;
		p    = $urandom();
		kind = $urandom_range(2);
		for (l = 0; l < LANES; l++) begin
			if (kind == 1) begin
				p[LANE_W*l +: LANE_W] = flat_level ^ LANE_W'($urandom_range(15));
			end else if (kind == 2) begin
				p[LANE_W*l +: LANE_W] = {LANE_W{p[LANE_W*l]}};
			end
		end
		return p;
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct <= 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct = 65;
				rx_stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct = 0;
				rx_stall_pct <= 65;
			end
			default: begin
				tx_idle_pct = 15;
				rx_stall_pct <= 15;
			end
		endcase
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] px, input bit typed,
			input sharp_beat_t typed_beat);
		bit          hit;
		sharp_beat_t beat;
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_pixel(px, hit, beat);
		pixels_sent++;
		if (hit) begin
			pending_beats.push_back(typed ? typed_beat : beat);
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom();
			@(posedge clk);
		end
	endtask

	task automatic stop_stream();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		stop_stream();
		while (pending_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  size_w = val[IMG_W_W-1:0];
			REG_IMAGE_HEIGHT: size_h = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: pixel_out %h", m_tdata[PIX_W-1:0]);
				errors++;
			end else begin
				head_beat = pending_beats.pop_front();
				beats_seen++;
				if (head_beat.last) begin
					frame_ends++;
				end
				if (m_tdata[PIX_W-1:0] !== head_beat.pix) begin
					$error("pixel_out: expected %h, got %h", head_beat.pix,
						m_tdata[PIX_W-1:0]);
					errors++;
				end
				if (m_tdata[PIX_W +: COL_OUT_W] !== head_beat.col) begin
					$error("out_col: expected %0d, got %0d", head_beat.col,
						m_tdata[PIX_W +: COL_OUT_W]);
					errors++;
				end
				if (m_tdata[PIX_W+COL_OUT_W +: ROW_W] !== head_beat.row) begin
					$error("out_row: expected %0d, got %0d", head_beat.row,
						m_tdata[PIX_W+COL_OUT_W +: ROW_W]);
					errors++;
				end
				if (m_tlast !== head_beat.last) begin
					$error("last_of_frame: expected %0b, got %0b", head_beat.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned n;
		for (n = 0; n < WATCHDOG_CYCLES; n++) begin
			@(posedge clk);
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int                    p;
		int                    i;
		int                    f;
		int                    n;
		logic [CFG_DATA_W-1:0] wv;
		logic [CFG_DATA_W-1:0] hv;
		probe_frame_t          pf;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: one full 640-pixel row and the start of the next. Border
		// rows give no beat.
		set_idling(IDLE_BOTH);
		flat_level = $urandom_range(255);
		for (i = 0; i < DEFAULT_W + LEAD_PIXELS; i++) begin
			push_pixel(rand_pixel(), 1'b0, '0);
		end

		// Shrinking both sizes below the minimum inside row one ends that row
		// with the next pixel, and three more pixels close the frame. Bits
		// above the width field are ignored.
		settle();
		write_reg(REG_IMAGE_WIDTH, 16'hE002);
		write_reg(REG_IMAGE_HEIGHT, 16'h0000);
		set_idling(IDLE_NONE);
		for (i = 0; i < CLOSE_PIXELS; i++) begin
			push_pixel(rand_pixel(), 1'b0, '0);
		end
		for (f = 0; f < 3; f++) begin
			pf = PROBE_FRAMES[f];
			for (i = 0; i < TAPS; i++) begin
				push_pixel((i == CENTER_TAP) ? pf.center : pf.ring, i == TAPS - 1,
					'{pf.want, COL_OUT_W'(1), ROW_W'(1), 1'b1});
			end
		end

		// Random phases. Widths stay within the columns that the reset-size
		// rows have already filled twice, so no line buffer entry is read
		// unwritten.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			wv = CFG_DATA_W'($urandom());
			case ($urandom_range(9))
				0:       wv[IMG_W_W-1:0] = IMG_W_W'($urandom_range(2));
				1:       wv[IMG_W_W-1:0] = IMG_W_W'($urandom_range(48, 13));
				default: wv[IMG_W_W-1:0] = IMG_W_W'($urandom_range(10, 3));
			endcase
			case ($urandom_range(9))
				0:       hv = CFG_DATA_W'($urandom_range(2));
				1:       hv = 16'hFFFF;
				2:       hv = CFG_DATA_W'($urandom_range(30, 9));
				default: hv = CFG_DATA_W'($urandom_range(8, 3));
			endcase
			write_reg(REG_IMAGE_WIDTH, wv);
			write_reg(REG_IMAGE_HEIGHT, hv);
			set_idling(idle_mode_t'(p % 4));
			flat_level = $urandom_range(255);
			if (p == 0) begin
				fork
					begin
						rx_hold <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end
			for (i = 0; i < PHASE_PIXELS; i++) begin
				push_pixel(rand_pixel(), 1'b0, '0);
				if (p == 1 && i == PHASE_PIXELS / 2) begin
					stop_stream();
					while (pending_beats.size() != 0) begin
						@(posedge clk);
					end
				end
			end
		end

		stop_stream();
		for (n = 0; n < END_WAIT_CYCLES && pending_beats.size() != 0; n++) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0) begin
			$error("%0d expected beats never arrived", pending_beats.size());
			errors += pending_beats.size();
		end
		$display("Sent %0d pixels: reset-size rows, clamped sizes, 3x3 probe frames",
			pixels_sent);
		$display("and %0d random phases; %0d beats checked, %0d frame ends, %0d mismatches.",
			RANDOM_PHASES, beats_seen, frame_ends, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
